FILE: rtl/core/vbsd_pkg.sv
package vbsd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned OWED_W  = 3;
    localparam int unsigned NIB_W   = 4;

    // form code held in bits 5:4 of a multi-byte header
    localparam logic [1:0] FORM_FOLLOW1 = 2'b00;
    localparam logic [1:0] FORM_FOLLOW2 = 2'b01;
    localparam logic [1:0] FORM_FOLLOW3 = 2'b10;
    localparam logic [1:0] FORM_WORD    = 2'b11;

    // top two header bits for the short negative form
    localparam logic [1:0] HDR_NEG = 2'b11;

    localparam logic [OWED_W-1:0] OWED_NONE = '0;
    localparam logic [OWED_W-1:0] OWED_ONE  = OWED_W'(1);
    localparam logic [OWED_W-1:0] OWED_TWO  = OWED_W'(2);
    localparam logic [OWED_W-1:0] OWED_THREE = OWED_W'(3);
    localparam logic [OWED_W-1:0] OWED_FOUR = OWED_W'(4);

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              is_last;
    } t_in_beat;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               truncated;
    } t_result;

endpackage

FILE: rtl/core/vbsd_in_reg.sv
module vbsd_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  vbsd_pkg::t_in_beat i_beat,
    output logic              o_valid,
    input  logic              i_take,
    output vbsd_pkg::t_in_beat o_beat
);
    import vbsd_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_beat r_beat;

    // a held beat frees its slot in the same cycle the decoder takes it
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

FILE: rtl/core/vbsd_decode.sv
module vbsd_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_take,
    input  vbsd_pkg::t_in_beat i_beat,
    output logic               o_valid,
    input  logic               i_ready,
    output vbsd_pkg::t_result  o_result
);
    import vbsd_pkg::*;

    logic [OWED_W-1:0]  r_owed;
    logic [OWED_W-1:0]  n_owed;
    logic [VALUE_W-1:0] r_acc;
    logic [VALUE_W-1:0] n_acc;
    logic               r_out_valid;
    logic               n_out_valid;
    t_result            r_result;
    logic               emit;
    t_result            res;
    logic [BYTE_W-1:0]  b;
    logic [VALUE_W-1:0] shifted;
    logic [OWED_W-1:0]  owed_dec;

    assign b        = i_beat.byte_in;
    assign shifted  = {r_acc[VALUE_W-BYTE_W-1:0], b};
    assign owed_dec = r_owed - OWED_ONE;

    // decoder moves only when the result slot is free or draining
    assign o_take   = i_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    always_comb begin
        emit      = 1'b0;
        res.value = '1;
        res.truncated = 1'b0;
        n_owed    = r_owed;
        n_acc     = r_acc;
        if (r_owed == OWED_NONE) begin
            if (!b[BYTE_W-1]) begin
                emit      = 1'b1;
                res.value = {{(VALUE_W-BYTE_W){1'b0}}, b};
            end else if (b[BYTE_W-1 -: 2] == HDR_NEG) begin
                emit      = 1'b1;
                res.value = {{(VALUE_W-BYTE_W){1'b1}}, b};
            end else begin
                n_acc = {{(VALUE_W-NIB_W){1'b0}}, b[NIB_W-1:0]};
                unique case (b[5:4])
                    FORM_FOLLOW1: n_owed = OWED_ONE;
                    FORM_FOLLOW2: n_owed = OWED_TWO;
                    FORM_FOLLOW3: n_owed = OWED_THREE;
                    FORM_WORD: begin
                        n_owed = OWED_FOUR;
                        n_acc  = '0;
                    end
                    default: n_owed = OWED_FOUR;
                endcase
                if (i_beat.is_last) begin
                    emit          = 1'b1;
                    res.truncated = 1'b1;
                end
            end
        end else begin
            n_acc  = shifted;
            n_owed = owed_dec;
            if (owed_dec == OWED_NONE) begin
                emit      = 1'b1;
                res.value = shifted;
            end else if (i_beat.is_last) begin
                emit          = 1'b1;
                res.truncated = 1'b1;
            end
        end
        if (emit) begin
            n_owed = OWED_NONE;
            n_acc  = '0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_take && emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owed      <= OWED_NONE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_owed <= n_owed;
                r_acc  <= n_acc;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_result <= res;
        end
    end

endmodule

FILE: rtl/core/varint_byte_stream_decoder_top.sv
// variable-length integer decoder for a byte stream
// input channel s_axis: one encoded byte per beat in tdata, tlast marks the
// final byte of a buffer; after a tlast beat the next byte is a new header
// output channel m_axis: one decoded signed 32-bit value per beat in tdata,
// tuser is the truncation flag (value is then all ones)
// a header byte 0..127 or 192..255 gives its value on its own; longer forms
// give a beat only once their last follow byte arrives, or on a tlast byte
// that leaves the value short
// a result beat reaches m_axis through the input register, then the result
// register, after the byte that completes it is accepted
// throughput: one byte per cycle while m_axis does not stall, set by the single
// decode step between the input register and the result register
// when m_axis stalls the result register holds its beat; one more byte is
// buffered in the input register, then s_axis_tready drops
// reset clears the byte count, the accumulator and both valid flags
module varint_byte_stream_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic        m_axis_tuser    // [0] truncated
);
    import vbsd_pkg::*;

    t_in_beat in_beat;
    t_in_beat held_beat;
    logic     held_valid;
    logic     dec_take;
    t_result  result;

    assign in_beat.byte_in = s_axis_tdata;
    assign in_beat.is_last = s_axis_tlast;

    vbsd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_beat  (in_beat),
        .o_valid (held_valid),
        .i_take  (dec_take),
        .o_beat  (held_beat)
    );

    vbsd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (held_valid),
        .o_take   (dec_take),
        .i_beat   (held_beat),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = result.value;
    assign m_axis_tuser = result.truncated;

endmodule

FILE: tb/varint_byte_stream_decoder_top_tb.sv
`timescale 1ns / 100ps

module varint_byte_stream_decoder_top_tb;

    import vbsd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BYTES  = 850;
    localparam int DRAIN_AT      = 400;
    localparam int TAIL_CYCLES   = 8;

    // decoded values still owed by the block, with a copy of its byte count and accumulator
    class varint_scoreboard;
        t_result                 pending_values[$];
        logic [OWED_W-1:0]       owed;
        logic [VALUE_W-1:0]      acc;
        int                      errors;
        int                      value_count;

        function new();
            owed        = OWED_NONE;
            acc         = '0;
            errors      = 0;
            value_count = 0;
        endfunction

        function void push_value(logic [VALUE_W-1:0] v, logic trunc);
            t_result r;
            r.value     = v;
            r.truncated = trunc;
            pending_values.push_back(r);
            owed = OWED_NONE;
            acc  = '0;
        endfunction

        // decode one accepted byte
        function void note_byte(logic [BYTE_W-1:0] b, logic last);
            if (owed == OWED_NONE) begin
                if (!b[7]) begin
                    push_value({24'd0, b}, 1'b0);
                end else if (b[7:6] == HDR_NEG) begin
                    push_value({{24{b[7]}}, b}, 1'b0);
                end else begin
                    case (b[5:4])
                        FORM_FOLLOW1: begin
                            owed = OWED_ONE;
                            acc  = {28'd0, b[3:0]};
                        end
                        FORM_FOLLOW2: begin
                            owed = OWED_TWO;
                            acc  = {28'd0, b[3:0]};
                        end
                        FORM_FOLLOW3: begin
                            owed = OWED_THREE;
                            acc  = {28'd0, b[3:0]};
                        end
                        default: begin
                            owed = OWED_FOUR;
                            acc  = '0;
                        end
                    endcase
                    if (last)
                        push_value('1, 1'b1);
                end
            end else begin
                acc  = {acc[VALUE_W-BYTE_W-1:0], b};
                owed = owed - OWED_ONE;
                if (owed == OWED_NONE)
                    push_value(acc, 1'b0);
                else if (last)
                    push_value('1, 1'b1);
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_value(logic [VALUE_W-1:0] v, logic trunc);
            t_result want;
            value_count++;
            if (pending_values.size() == 0) begin
                report($sformatf("beat %0d: unexpected value %h truncated %0b",
                                 value_count, v, trunc));
            end else begin
                want = pending_values.pop_front();
                if (v !== want.value)
                    report($sformatf("beat %0d: value %h, want %h",
                                     value_count, v, want.value));
                if (trunc !== want.truncated)
                    report($sformatf("beat %0d: truncated %b, want %b",
                                     value_count, trunc, want.truncated));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] byte_in
    logic        s_axis_tlast;    // is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // [31:0] value
    logic        m_axis_tuser;    // [0] truncated

    varint_scoreboard sb;
    int cycles;
    int bytes_sent;
    int burst_left;
    int rx_cycle;
    int stall_hold;
    logic rx_ready_next;

    varint_byte_stream_decoder_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: rotates through always ready, light, heavy and long stalls
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_value(m_axis_tdata, m_axis_tuser);
        rx_cycle++;
        case (rx_cycle[8:7])
            2'd0: rx_ready_next = 1'b1;
            2'd1: rx_ready_next = ($urandom_range(0, 3) != 0);
            2'd2: rx_ready_next = 1'($urandom_range(0, 1));
            default: begin
                rx_ready_next = m_axis_tready;
                if (stall_hold > 0) begin
                    stall_hold--;
                end else begin
                    rx_ready_next = ~m_axis_tready;
                    stall_hold    = $urandom_range(0, 10);
                end
            end
        endcase
        m_axis_tready <= rx_ready_next;
    end

    // one beat on s_axis, after a random gap when a burst has run out
    task send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b, last);
        burst_left--;
        bytes_sent++;
    endtask

    // follow bytes lean toward the edges of the byte range
    function logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: pick_byte = 8'h00;
            1: pick_byte = 8'hFF;
            2: pick_byte = 8'h80;
            3: pick_byte = 8'h7F;
            default: pick_byte = 8'($urandom_range(0, 255));
        endcase
    endfunction

    function logic [7:0] pick_header(logic [1:0] form);
        pick_header = {2'b10, form, 4'($urandom_range(0, 15))};
    endfunction

    function int follow_count(logic [1:0] form);
        case (form)
            FORM_FOLLOW1: follow_count = 1;
            FORM_FOLLOW2: follow_count = 2;
            FORM_FOLLOW3: follow_count = 3;
            default:      follow_count = 4;
        endcase
    endfunction

    initial begin
        int kind;
        int n;
        int cut;
        logic [1:0] form;
        bit drained;

        sb            = new();
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        cycles        = 0;
        bytes_sent    = 0;
        burst_left    = 0;
        rx_cycle      = 0;
        stall_hold    = 0;
        drained       = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-byte forms at their edges, one ending a buffer
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hC0, 1'b0);
        send_byte(8'hFF, 1'b0);
        // 12 and 28 bit forms at full scale, 20 bit form with a mixed value
        send_byte({2'b10, FORM_FOLLOW1, 4'hF}, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte({2'b10, FORM_FOLLOW2, 4'h1}, 1'b0);
        send_byte(8'h23, 1'b0);
        send_byte(8'h45, 1'b0);
        send_byte({2'b10, FORM_FOLLOW3, 4'hF}, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // full word: most negative, low nibble of the header ignored
        send_byte({2'b10, FORM_WORD, 4'h7}, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        // buffer ends right on a multi-byte header
        send_byte({2'b10, FORM_FOLLOW3, 4'h3}, 1'b1);
        // buffer ends on a follow byte with more owed
        send_byte({2'b10, FORM_FOLLOW2, 4'hA}, 1'b0);
        send_byte(8'h12, 1'b1);
        send_byte({2'b10, FORM_WORD, 4'h0}, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hBB, 1'b0);
        send_byte(8'hCC, 1'b1);

        while (bytes_sent < RANDOM_BYTES) begin
            if (!drained && bytes_sent >= DRAIN_AT) begin
                // hold the stream until every owed value is out
                drained = 1;
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (sb.pending_values.size() != 0);
                burst_left = 0;
            end
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
                send_byte(8'($urandom_range(0, 127)), $urandom_range(0, 5) == 0);
            end else if (kind < 30) begin
                send_byte(8'($urandom_range(192, 255)), $urandom_range(0, 5) == 0);
            end else if (kind < 80) begin
                form = 2'($urandom_range(0, 3));
                n    = follow_count(form);
                send_byte(pick_header(form), 1'b0);
                for (int i = 0; i < n; i++)
                    send_byte(pick_byte(), (i == n - 1) && ($urandom_range(0, 5) == 0));
            end else if (kind < 92) begin
                // cut short by the end of the buffer
                form = 2'($urandom_range(0, 3));
                n    = follow_count(form);
                cut  = $urandom_range(0, n - 1);
                send_byte(pick_header(form), cut == 0);
                for (int i = 0; i < cut; i++)
                    send_byte(pick_byte(), i == cut - 1);
            end else begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_values.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending_values.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/vbsd_pkg.sv
rtl/core/vbsd_in_reg.sv
rtl/core/vbsd_decode.sv
rtl/core/varint_byte_stream_decoder_top.sv
tb/varint_byte_stream_decoder_top_tb.sv
